### sv/stel_pkg.sv
`default_nettype none

package stel_pkg;

    localparam int MaxNodes = 16;
    localparam int IdW      = 4;
    localparam int CountW   = 5;
    localparam int StateW   = 5;
    localparam int CountRegW = 4;

    localparam logic [StateW-1:0] NoneId = 5'd31;

    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_ACK    = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_NODE_ID    = 1'b0,
        CFG_NODE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [MaxNodes-1:0] mask;
        logic [IdW-1:0]      root;
        kind_t               kind;
        logic                done;
    } job_t;

endpackage

`default_nettype wire

### sv/stel_core.sv
`default_nettype none

module stel_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wen,
    input  wire logic                   cfg_index,
    input  wire logic [4:0]             cfg_wdata,
    input  wire logic                   take,
    input  wire logic                   mode,
    input  wire logic [3:0]             msg_root,
    input  wire logic [1:0]             msg_kind,
    input  wire logic [3:0]             msg_source,
    output stel_pkg::job_t              job
);

    logic [stel_pkg::IdW-1:0]       node_id_reg;
    logic [stel_pkg::CountW-1:0]    node_count_reg;
    logic [stel_pkg::StateW-1:0]    best_root_reg, best_root_next;
    logic [stel_pkg::StateW-1:0]    parent_node_reg, parent_node_next;
    logic [stel_pkg::CountRegW-1:0] queries_sent_reg, queries_sent_next;
    logic [stel_pkg::CountRegW-1:0] replies_seen_reg, replies_seen_next;
    logic                           halted_reg, halted_next;

    logic [stel_pkg::CountW-1:0]    active_n;
    logic [stel_pkg::MaxNodes-1:0]  range_mask;
    logic [stel_pkg::MaxNodes-1:0]  bc_cur, bc_src, src_hot, parent_hot;
    logic [stel_pkg::CountW-1:0]    bc_cur_cnt, bc_src_cnt;
    logic [stel_pkg::CountRegW-1:0] replies_inc;
    logic                           id_mult3;
    stel_pkg::kind_t                kind_in;

    function automatic logic [stel_pkg::MaxNodes-1:0] onehot(input logic [3:0] idx);
        logic [stel_pkg::MaxNodes-1:0] v;
        v = '0;
        v[idx] = 1'b1;
        return v;
    endfunction

    function automatic logic [stel_pkg::MaxNodes-1:0] bcast(
        input logic [stel_pkg::MaxNodes-1:0] rng,
        input logic [3:0]                    self_id,
        input logic [stel_pkg::StateW-1:0]   parent
    );
        logic [stel_pkg::MaxNodes-1:0] v;
        v = rng & ~onehot(self_id);
        if (parent != stel_pkg::NoneId) begin
            v = v & ~onehot(parent[3:0]);
        end
        return v;
    endfunction

    assign kind_in = stel_pkg::kind_t'(msg_kind);

    always_comb begin
        unique case (node_id_reg)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: id_mult3 = 1'b1;
            default:                              id_mult3 = 1'b0;
        endcase
    end

    assign active_n = (node_count_reg > stel_pkg::CountW'(stel_pkg::MaxNodes))
                    ? stel_pkg::CountW'(stel_pkg::MaxNodes) : node_count_reg;

    always_comb begin
        for (int i = 0; i < stel_pkg::MaxNodes; i++) begin
            range_mask[i] = (stel_pkg::CountW'(i) < active_n);
        end
    end

    assign bc_cur     = bcast(range_mask, node_id_reg, parent_node_reg);
    assign bc_src     = bcast(range_mask, node_id_reg, {1'b0, msg_source});
    assign bc_cur_cnt = stel_pkg::CountW'($countones(bc_cur));
    assign bc_src_cnt = stel_pkg::CountW'($countones(bc_src));
    assign src_hot    = onehot(msg_source);
    assign parent_hot = onehot(parent_node_reg[3:0]);
    assign replies_inc = replies_seen_reg + 4'd1;

    always_comb begin
        best_root_next    = best_root_reg;
        parent_node_next  = parent_node_reg;
        queries_sent_next = queries_sent_reg;
        replies_seen_next = replies_seen_reg;
        halted_next       = halted_reg;
        job               = '0;
        job.kind          = stel_pkg::KIND_QUERY;
        if (!halted_reg) begin
            if (!mode) begin
                if (id_mult3) begin
                    best_root_next    = {1'b0, node_id_reg};
                    queries_sent_next = bc_cur_cnt[3:0];
                    job.mask          = bc_cur;
                    job.root          = node_id_reg;
                    job.kind          = stel_pkg::KIND_QUERY;
                    job.done          = (bc_cur == '0);
                end
            end else begin
                unique case (kind_in)
                    stel_pkg::KIND_QUERY: begin
                        if (best_root_reg == stel_pkg::NoneId ||
                            {1'b0, msg_root} < best_root_reg) begin
                            best_root_next    = {1'b0, msg_root};
                            parent_node_next  = {1'b0, msg_source};
                            replies_seen_next = '0;
                            queries_sent_next = bc_src_cnt[3:0];
                            job.root          = msg_root;
                            if (bc_src == '0) begin
                                job.mask = src_hot;
                                job.kind = stel_pkg::KIND_ACCEPT;
                                job.done = 1'b1;
                            end else begin
                                job.mask = bc_src;
                                job.kind = stel_pkg::KIND_QUERY;
                            end
                        end else begin
                            job.mask = src_hot;
                            job.root = best_root_reg[3:0];
                            job.kind = stel_pkg::KIND_REJECT;
                        end
                    end
                    stel_pkg::KIND_ACCEPT, stel_pkg::KIND_REJECT: begin
                        if (best_root_reg != stel_pkg::NoneId &&
                            {1'b0, msg_root} == best_root_reg) begin
                            replies_seen_next = replies_inc;
                            if (replies_inc == queries_sent_reg) begin
                                job.root = best_root_reg[3:0];
                                if (parent_node_reg != stel_pkg::NoneId) begin
                                    job.mask = parent_hot;
                                    job.kind = stel_pkg::KIND_ACCEPT;
                                end else begin
                                    job.mask = bc_cur;
                                    job.kind = stel_pkg::KIND_ACK;
                                    job.done = 1'b1;
                                end
                            end
                        end
                    end
                    stel_pkg::KIND_ACK: begin
                        job.done = 1'b1;
                        job.root = msg_root;
                        job.kind = stel_pkg::KIND_ACK;
                        if (parent_node_reg == stel_pkg::NoneId ||
                            {1'b0, msg_source} != parent_node_reg) begin
                            job.mask = bc_cur;
                        end
                    end
                    default: ;
                endcase
            end
            halted_next = job.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg      <= '0;
            node_count_reg   <= stel_pkg::CountW'(16);
            best_root_reg    <= stel_pkg::NoneId;
            parent_node_reg  <= stel_pkg::NoneId;
            queries_sent_reg <= '0;
            replies_seen_reg <= '0;
            halted_reg       <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (stel_pkg::cfg_index_t'(cfg_index))
                    stel_pkg::CFG_NODE_ID:    node_id_reg    <= cfg_wdata[3:0];
                    stel_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (take) begin
                best_root_reg    <= best_root_next;
                parent_node_reg  <= parent_node_next;
                queries_sent_reg <= queries_sent_next;
                replies_seen_reg <= replies_seen_next;
                halted_reg       <= halted_next;
            end
        end
    end

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted node resumed");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> job.mask == '0)
        else $error("halted node produced a request");

    a_done_sets_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        take && job.done |=> halted_reg)
        else $error("done run did not halt node");

endmodule

`default_nettype wire

### sv/stel_emit.sv
`default_nettype none

module stel_emit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  stel_pkg::job_t      job_in,
    output logic                job_free,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    stel_pkg::job_t                job_reg;
    logic                          out_valid_reg;
    logic [3:0]                    out_dest_reg, out_root_reg;
    stel_pkg::kind_t               out_kind_reg;
    logic                          out_last_reg, out_done_reg;

    logic                          emit_now;
    logic [stel_pkg::MaxNodes-1:0] low_bit, rem_mask;
    logic [3:0]                    low_idx;

    assign low_bit  = job_reg.mask & (~job_reg.mask + 1'b1);
    assign rem_mask = job_reg.mask & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < stel_pkg::MaxNodes; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | 4'(i);
            end
        end
    end

    assign emit_now = (job_reg.mask != '0) && (!out_valid_reg || m_tready);
    assign job_free = (job_reg.mask == '0) || (emit_now && rem_mask == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg.mask  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                job_reg.mask <= job_in.mask;
            end else if (emit_now) begin
                job_reg.mask <= rem_mask;
            end
            if (emit_now) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg.root <= job_in.root;
            job_reg.kind <= job_in.kind;
            job_reg.done <= job_in.done;
        end
        if (emit_now) begin
            out_dest_reg <= low_idx;
            out_root_reg <= job_reg.root;
            out_kind_reg <= job_reg.kind;
            out_last_reg <= (rem_mask == '0);
            out_done_reg <= job_reg.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_kind_reg, out_root_reg, out_dest_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_now && rem_mask != '0 |=> m_tvalid && !m_tlast)
        else $error("last flag set before run end");

    a_mask_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        job_reg.mask != '0 && !emit_now |=> job_reg.mask == $past(job_reg.mask))
        else $error("pending destinations changed while stalled");

endmodule

`default_nettype wire

### sv/spanning_tree_election_node.sv
// One node of a fully connected spanning-tree election network.
// Slave channel: one request per item. s_tuser is the mode (0 start,
// 1 message arrived); s_tdata carries msg_root, msg_kind, msg_source.
// Master channel: one request per outgoing message; m_tdata carries
// dest_node, out_root, out_kind; m_tlast marks the final message of a run;
// m_tuser is node_done, set on every message of a run after which the node
// halts. Once halted the node takes items and produces nothing.
// Configuration: cfg_wen/cfg_index/cfg_wdata write node_id (index 0) or
// node_count (index 1) at once; write only while idle.
// An accepted item passes the input, job and output registers before its
// first message is valid. Throughput: one item per cycle while each item
// yields at most one message and m_tready does not stall; a broadcast run
// holds the next item while the emitter walks its mask, one per cycle unless stalled.
// Reset (aresetn low, synchronous): node_id 0, node_count 16, no root, no
// parent, counts cleared, not halted, both channels empty.
// A stall on m_tready holds the output register and the pending run, then
// the one-item input register, then drops s_tready; nothing is lost.
`default_nettype none

module spanning_tree_election_node (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // msg_root[3:0], msg_kind[5:4], msg_source[9:6]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // dest_node[3:0], out_root[7:4], out_kind[9:8]
    output logic             m_tlast,
    output logic             m_tuser    // node_done
);

    logic           in_valid_reg;
    logic           in_mode_reg;
    logic [3:0]     in_root_reg, in_source_reg;
    logic [1:0]     in_kind_reg;
    logic           job_free, take;
    stel_pkg::job_t job;

    assign take     = in_valid_reg && job_free;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg   <= s_tuser;
            in_root_reg   <= s_tdata[3:0];
            in_kind_reg   <= s_tdata[5:4];
            in_source_reg <= s_tdata[9:6];
        end
    end

    stel_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .take       (take),
        .mode       (in_mode_reg),
        .msg_root   (in_root_reg),
        .msg_kind   (in_kind_reg),
        .msg_source (in_source_reg),
        .job        (job)
    );

    stel_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .job_in   (job),
        .job_free (job_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
